@@ rtl/core/wsg_pkg.sv @@
// shared types, constants and write decoder of the wavetable sound generator
`default_nettype none

package wsg_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int WAVE_STEPS   = 32;
    localparam int WAVE_DEPTH   = NUM_CHANNELS * WAVE_STEPS;
    localparam int WAVE_AW      = $clog2(WAVE_DEPTH);
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int STEP_W       = $clog2(WAVE_STEPS);

    localparam int BYTE_W    = 8;
    localparam int CLK_W     = 26;
    localparam int SR_W      = 18;
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 1;
    localparam int PER_W     = 12;
    localparam int VOL_W     = 4;
    localparam int PHASE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = CLK_W + FRAC_W;
    localparam int DEN_W     = PER_W + 1 + SR_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int ACC_W     = 15;
    localparam int MIX_W     = 17;

    localparam logic [CLK_W-1:0] CHIP_CLOCK_RST  = CLK_W'(1789772);
    localparam logic [SR_W-1:0]  SAMPLE_RATE_RST = SR_W'(44100);

    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_CLOCK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b1;

    localparam logic OP_TICK = 1'b1;

    localparam logic [BYTE_W-1:0] PORT_DIRECT     = 8'h00;
    localparam logic [BYTE_W-1:0] PORT_PERIOD     = 8'h01;
    localparam logic [BYTE_W-1:0] PORT_VOLUME     = 8'h02;
    localparam logic [BYTE_W-1:0] PORT_ENABLE     = 8'h03;
    localparam logic [BYTE_W-1:0] PER_REG_LAST    = 8'h09;
    localparam logic [BYTE_W-1:0] VOL_REG_LAST    = 8'h04;
    localparam logic [BYTE_W-1:0] WAVE_ADDR_LAST  = 8'h9F;
    localparam logic [BYTE_W-1:0] DIR_PER_FIRST   = 8'hA0;
    localparam logic [BYTE_W-1:0] DIR_PER_LAST    = 8'hA9;
    localparam logic [BYTE_W-1:0] DIR_VOL_FIRST   = 8'hAA;
    localparam logic [BYTE_W-1:0] DIR_VOL_LAST    = 8'hAE;
    localparam logic [BYTE_W-1:0] DIR_ENABLE      = 8'hAF;
    localparam logic [CH_W-1:0]   MIRROR_SRC_CH   = 3'd3;
    localparam logic [CH_W-1:0]   MIRROR_DST_CH   = 3'd4;

    typedef enum logic [2:0] {
        WK_NONE,
        WK_WAVE,
        WK_MIRROR,
        WK_PERIOD,
        WK_VOLUME,
        WK_ENABLE
    } t_wr_kind;

    typedef struct packed {
        t_wr_kind            kind;
        logic [BYTE_W-1:0]   offs;
    } t_wr_dec;

    typedef struct packed {
        logic load;
        logic wave_wr;
        logic mirror_wr;
        logic reg_wr;
        logic per_wr;
        logic den_load;
        logic div_step;
        logic step_wr;
        logic ph_adv;
        logic mix_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic     in_op;
        t_wr_kind in_kind;
        t_wr_kind kind;
        logic     div_last;
        logic     last_ch;
        logic     out_free;
    } t_sts;

    function automatic t_wr_dec wr_decode(input logic [BYTE_W-1:0] port,
                                          input logic [BYTE_W-1:0] addr);
        t_wr_dec d;
        d.kind = WK_NONE;
        d.offs = addr;
        priority if (port == PORT_PERIOD) begin
            if (addr <= PER_REG_LAST) d.kind = WK_PERIOD;
        end else if (port == PORT_VOLUME) begin
            if (addr <= VOL_REG_LAST) d.kind = WK_VOLUME;
        end else if (port == PORT_ENABLE) begin
            d.kind = WK_ENABLE;
        end else if (port == PORT_DIRECT) begin
            priority if (addr <= WAVE_ADDR_LAST) begin
                d.kind = (addr[BYTE_W-1:STEP_W] == MIRROR_SRC_CH) ? WK_MIRROR : WK_WAVE;
            end else if (addr >= DIR_PER_FIRST && addr <= DIR_PER_LAST) begin
                d.kind = WK_PERIOD;
                d.offs = addr - DIR_PER_FIRST;
            end else if (addr >= DIR_VOL_FIRST && addr <= DIR_VOL_LAST) begin
                d.kind = WK_VOLUME;
                d.offs = addr - DIR_VOL_FIRST;
            end else if (addr == DIR_ENABLE) begin
                d.kind = WK_ENABLE;
            end else begin
                d.kind = WK_NONE;
            end
        end else begin
            d.kind = WK_NONE;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/wsg_in_if.sv @@
// input channel: register writes and ticks
`default_nettype none

interface wsg_in_if import wsg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] port;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] wdata;

    modport source (output valid, output operation, output port, output reg_addr,
                    output wdata, input ready);
    modport sink   (input valid, input operation, input port, input reg_addr,
                    input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wsg_out_if.sv @@
// output channel: mixed samples
`default_nettype none

interface wsg_out_if import wsg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mix_sample;

    modport source (output valid, output mix_sample, input ready);
    modport sink   (input valid, input mix_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wsg_ctrl.sv @@
// controller state machine sequencing writes, step division and ticks
`default_nettype none

module wsg_ctrl import wsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAVE,
        S_MIRROR,
        S_REG,
        S_PERIOD,
        S_DEN,
        S_DIV,
        S_STEP,
        S_PHASE,
        S_MIX,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_op == OP_TICK) begin
                        n_state = S_PHASE;
                    end else begin
                        unique case (i_sts.in_kind)
                            WK_WAVE, WK_MIRROR:  n_state = S_WAVE;
                            WK_PERIOD:           n_state = S_PERIOD;
                            WK_VOLUME, WK_ENABLE: n_state = S_REG;
                            default:             n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_WAVE: begin
                o_cmd.wave_wr = 1'b1;
                n_state = (i_sts.kind == WK_MIRROR) ? S_MIRROR : S_IDLE;
            end
            S_MIRROR: begin
                o_cmd.mirror_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_REG: begin
                o_cmd.reg_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_PERIOD: begin
                o_cmd.per_wr = 1'b1;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.step_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_PHASE: begin
                o_cmd.ph_adv = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix_acc = 1'b1;
                n_state = i_sts.last_ch ? S_OUT : S_PHASE;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step_wr |-> ($past(o_cmd.div_step) && $past(i_sts.div_last)))
        else $error("phase step stored before the division finished");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten while full");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_sts.in_op == OP_TICK) |=> (r_state == S_PHASE))
        else $error("accepted tick did not start the channel sweep");

endmodule

`default_nettype wire

@@ rtl/core/wsg_dp.sv @@
// datapath: channel registers, wave ram, step divider, mixer and output register
`default_nettype none

module wsg_dp import wsg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_operation,
    input  logic [BYTE_W-1:0]       i_port,
    input  logic [BYTE_W-1:0]       i_reg_addr,
    input  logic [BYTE_W-1:0]       i_wdata,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [MIX_W-1:0] o_mix_sample
);

    logic [CLK_W-1:0]   r_chip_clock;
    logic [SR_W-1:0]    r_sample_rate;

    t_wr_dec            in_dec;
    t_wr_kind           r_kind;
    logic [BYTE_W-1:0]  r_offs;
    logic [BYTE_W-1:0]  r_wdata;

    logic [PER_W-1:0]   r_period [NUM_CHANNELS];
    logic [PHASE_W-1:0] r_step   [NUM_CHANNELS];
    logic [PHASE_W-1:0] r_phase  [NUM_CHANNELS];
    logic [VOL_W-1:0]   r_vol    [NUM_CHANNELS];
    logic [BYTE_W-1:0]  r_enable;

    logic [BYTE_W-1:0]     r_mem [WAVE_DEPTH];
    logic [WAVE_DEPTH-1:0] r_valid;
    logic [BYTE_W-1:0]     r_rd_data;
    logic                  r_rd_valid;
    logic                  wr_en;
    logic [WAVE_AW-1:0]    wr_addr;
    logic [WAVE_AW-1:0]    rd_addr;

    logic [CH_W-1:0]    per_ch;
    logic [PER_W:0]     per_p1;
    logic [DEN_W-1:0]   den_prod;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_rem;
    logic [PHASE_W-1:0] r_quo;
    logic [CNT_W-1:0]   r_div_cnt;
    logic               r_per_zero;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_diff;
    logic               rem_ge;

    logic [CH_W-1:0]             r_ch;
    logic [PHASE_W-1:0]          new_phase;
    logic signed [BYTE_W-1:0]    smp;
    logic signed [VOL_W:0]       vol_s;
    logic signed [ACC_W-1:0]     prod;
    logic signed [ACC_W-1:0]     r_mix;
    logic signed [MIX_W-1:0]     mix_ext;
    logic signed [MIX_W-1:0]     mix6;
    logic                        r_out_valid;
    logic signed [MIX_W-1:0]     r_out_data;

    assign in_dec = wr_decode(i_port, i_reg_addr);

    assign per_ch   = r_offs[CH_W:1];
    assign per_p1   = {1'b0, r_period[per_ch]} + (PER_W+1)'(1);
    assign den_prod = DEN_W'(per_p1) * DEN_W'(r_sample_rate);

    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_den};
    assign rem_diff = rem_sh - {1'b0, r_den};

    assign new_phase = r_phase[r_ch] + r_step[r_ch];
    assign rd_addr   = {r_ch, new_phase[FRAC_W+STEP_W-1:FRAC_W]};
    assign smp       = r_rd_valid ? signed'(r_rd_data) : '0;
    assign vol_s     = signed'({1'b0, r_vol[r_ch]});
    assign prod      = ACC_W'(smp * vol_s);
    assign mix_ext   = MIX_W'(r_mix);
    assign mix6      = (mix_ext <<< 2) + (mix_ext <<< 1);

    assign wr_en   = i_cmd.wave_wr || i_cmd.mirror_wr;
    assign wr_addr = i_cmd.mirror_wr ? {MIRROR_DST_CH, r_offs[STEP_W-1:0]}
                                     : r_offs[WAVE_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_clock  <= CHIP_CLOCK_RST;
            r_sample_rate <= SAMPLE_RATE_RST;
            r_enable      <= '0;
            r_valid       <= '0;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_period[i] <= '0;
                r_step[i]   <= '0;
                r_phase[i]  <= '0;
                r_vol[i]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CHIP_CLOCK:  r_chip_clock  <= i_cfg_wdata[CLK_W-1:0];
                    CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_wdata[SR_W-1:0];
                endcase
            end
            if (wr_en) r_valid[wr_addr] <= 1'b1;
            if (i_cmd.ph_adv) begin
                r_rd_valid <= r_valid[rd_addr];
                if (r_enable[r_ch]) r_phase[r_ch] <= new_phase;
            end
            if (i_cmd.reg_wr) begin
                if (r_kind == WK_VOLUME) r_vol[r_offs[CH_W-1:0]] <= r_wdata[VOL_W-1:0];
                else r_enable <= r_wdata;
            end
            if (i_cmd.per_wr) begin
                if (!r_offs[0]) r_period[per_ch][BYTE_W-1:0] <= r_wdata;
                else r_period[per_ch][PER_W-1:BYTE_W] <= r_wdata[PER_W-BYTE_W-1:0];
            end
            if (i_cmd.step_wr) r_step[per_ch] <= r_per_zero ? '0 : r_quo;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= r_wdata;
        if (i_cmd.ph_adv) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= in_dec.kind;
            r_offs  <= in_dec.offs;
            r_wdata <= i_wdata;
            r_ch    <= '0;
            r_mix   <= '0;
        end
        if (i_cmd.den_load) begin
            r_den      <= den_prod;
            r_num      <= {r_chip_clock, {FRAC_W{1'b0}}};
            r_rem      <= '0;
            r_quo      <= '0;
            r_div_cnt  <= '0;
            r_per_zero <= (r_period[per_ch] == '0);
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_num     <= {r_num[NUM_W-2:0], 1'b0};
            r_quo     <= {r_quo[PHASE_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
        if (i_cmd.mix_acc) begin
            if (r_enable[r_ch]) r_mix <= r_mix + prod;
            r_ch <= r_ch + CH_W'(1);
        end
        if (i_cmd.out_load) r_out_data <= mix6;
    end

    assign o_sts.in_op    = i_operation;
    assign o_sts.in_kind  = in_dec.kind;
    assign o_sts.kind     = r_kind;
    assign o_sts.div_last = (r_div_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.last_ch  = (r_ch == CH_W'(NUM_CHANNELS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_mix_sample = r_out_data;

    a_mix_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mix_acc |-> $past(i_cmd.ph_adv))
        else $error("mix accumulated without a fresh wave ram read");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ph_adv |-> (r_ch < CH_W'(NUM_CHANNELS)))
        else $error("channel counter ran past the last channel");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_wr |-> (r_div_cnt == CNT_W'(DIV_STEPS)))
        else $error("phase step stored after a short division");

endmodule

`default_nettype wire

@@ rtl/core/wavetable_sound_generator_5ch_top.sv @@
// top level of the five-channel wavetable sound generator
`default_nettype none

// Five-channel wavetable sound generator. Each input word is either a register write
// (wave RAM byte, 12-bit period, 4-bit volume or enable mask) or a tick that yields one
// mixed sample word. Items are taken one at a time: an ignored write changes nothing, a
// volume or enable write stores the register, a wave RAM write stores the byte and may
// mirror it into channel 4, and a period write updates the period, multiplies out the
// divisor and then computes the phase step in a 42-step restoring divider producing one
// quotient bit per cycle. A tick runs, for each channel, the phase add with wave RAM read
// and then the multiply-add, and then loads the output register, waiting while the
// previous sample has not been taken. The wave RAM is a store with separate write and
// read addresses whose entries read as zero until written, so no clearing pass follows
// reset. Changing the chip clock or sample rate affects only steps computed by later
// period writes.
module wavetable_sound_generator_5ch_top import wsg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    wsg_in_if.sink               i_in,
    wsg_out_if.source            o_out
);

    t_cmd                    cmd;
    t_sts                    sts;
    logic                    in_ready;
    logic                    out_valid;
    logic signed [MIX_W-1:0] mix_sample;

    wsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wsg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_operation  (i_in.operation),
        .i_port       (i_in.port),
        .i_reg_addr   (i_in.reg_addr),
        .i_wdata      (i_in.wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (out_valid),
        .o_mix_sample (mix_sample)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = out_valid;
    assign o_out.mix_sample = mix_sample;

endmodule

`default_nettype wire
